FILE: rtl/plo_pkg.sv
// Package for the path length odometer: shared types and constants.
// Used by plo_front, plo_queue, plo_back and path_length_odometer.
// Depends on nothing.
`timescale 1ns / 1ps

package plo_pkg;

    localparam int unsigned LIMIT_W     = 16;  // jump limit and step width
    localparam int unsigned TOTAL_OUT_W = 48;  // total_distance port width
    localparam int unsigned POS_W       = 32;  // coordinate port width
    localparam int unsigned SQ_W        = 33;  // ax*ax + ay*ay with ax, ay below 2^16
    localparam int unsigned ROOT_W      = 18;  // trial root bits, 17 down to 0
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2048;

    // What the back end has to do with one beat.
    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_FIRST,
        KIND_REJECT,
        KIND_MEASURE
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [LIMIT_W-1:0]  ax;
        logic [LIMIT_W-1:0]  ay;
        logic                seen;
    } entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQX,
        BK_SQY,
        BK_ROOT,
        BK_DONE
    } back_state_t;

endpackage

FILE: rtl/path_length_odometer.sv
// Top level of the path length odometer: jump limit register, front end,
// queue and back end. Depends on plo_pkg, plo_front, plo_queue, plo_back.
//
//   port group      dir   handshake             carries
//   in_*            in    in_valid / in_ready   mode, pos_x, pos_y
//   out_*           out   out_valid / out_ready total_distance, step_distance,
//                                               step_rejected, data_seen
//   cfg_*           in    cfg_we                cfg_wdata -> jump_limit
//
// A measured step passes through the back end as a queue pop, squaring ax and then
// ay on the shared 16x16 squarer, 18 root iterations and an update of the total.
// Clears, first samples and steps rejected on a single delta skip squarer and root.
// The front end takes one beat per cycle while the two-entry queue has room.
// Reset clears the position state, the total, the queue and the result valid flag.
// A stalled result holds in its register while the front accepts until the queue fills.
`timescale 1ns / 1ps

module path_length_odometer #(
    parameter int COORD_WIDTH = 32,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic signed [plo_pkg::POS_W-1:0] pos_x,
    input  logic signed [plo_pkg::POS_W-1:0] pos_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [plo_pkg::TOTAL_OUT_W-1:0] total_distance,
    output logic [plo_pkg::LIMIT_W-1:0]     step_distance,
    output logic                            step_rejected,
    output logic                            data_seen,
    input  logic                            cfg_we,
    input  logic [plo_pkg::LIMIT_W-1:0]     cfg_wdata
);

    logic [plo_pkg::LIMIT_W-1:0] jump_limit_reg;
    plo_pkg::entry_t             push_entry;
    logic                        push_valid;
    logic                        push_ready;
    plo_pkg::entry_t             pop_entry;
    logic                        pop_valid;
    logic                        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            jump_limit_reg <= plo_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            jump_limit_reg <= cfg_wdata;
        end
    end

    plo_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .jump_limit (jump_limit_reg),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    plo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop        (pop)
    );

    plo_back #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_entry      (pop_entry),
        .pop_valid      (pop_valid),
        .pop            (pop),
        .jump_limit     (jump_limit_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_distance (total_distance),
        .step_distance  (step_distance),
        .step_rejected  (step_rejected),
        .data_seen      (data_seen)
    );

endmodule

FILE: rtl/plo_front.sv
// Front end of the path length odometer: accepts beats, tracks the previous
// position and classifies each beat into a queue entry.
// Depends on plo_pkg.
`timescale 1ns / 1ps

module plo_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic signed [plo_pkg::POS_W-1:0] pos_x,
    input  logic signed [plo_pkg::POS_W-1:0] pos_y,
    input  logic [plo_pkg::LIMIT_W-1:0]   jump_limit,
    output plo_pkg::entry_t               push_entry,
    output logic                          push_valid,
    input  logic                          push_ready
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] x_c;
    logic signed [COORD_WIDTH-1:0] y_c;
    logic signed [COORD_WIDTH-1:0] last_x_reg, last_x_next;
    logic signed [COORD_WIDTH-1:0] last_y_reg, last_y_next;
    logic                          have_last_reg, have_last_next;
    logic                          seen_any_reg, seen_any_next;
    logic signed [DW-1:0]          dx;
    logic signed [DW-1:0]          dy;
    logic [DW-1:0]                 ax_full;
    logic [DW-1:0]                 ay_full;
    logic [DW-1:0]                 limit_ext;
    logic                          too_far;
    logic                          accept;

    generate
        if (COORD_WIDTH <= plo_pkg::POS_W) begin : g_narrow
            assign x_c = pos_x[COORD_WIDTH-1:0];
            assign y_c = pos_y[COORD_WIDTH-1:0];
        end else begin : g_wide
            assign x_c = COORD_WIDTH'(pos_x);
            assign y_c = COORD_WIDTH'(pos_y);
        end
    endgenerate

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    assign dx        = DW'(x_c) - DW'(last_x_reg);
    assign dy        = DW'(y_c) - DW'(last_y_reg);
    assign ax_full   = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay_full   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign limit_ext = DW'(jump_limit);
    assign too_far   = (ax_full >= limit_ext) || (ay_full >= limit_ext);

    always_comb
    begin
        push_entry.ax   = ax_full[plo_pkg::LIMIT_W-1:0];
        push_entry.ay   = ay_full[plo_pkg::LIMIT_W-1:0];
        push_entry.seen = mode ? seen_any_reg : 1'b1;
        if (mode) begin
            push_entry.kind = plo_pkg::KIND_CLEAR;
        end else if (!have_last_reg) begin
            push_entry.kind = plo_pkg::KIND_FIRST;
        end else if (too_far) begin
            push_entry.kind = plo_pkg::KIND_REJECT;
        end else begin
            push_entry.kind = plo_pkg::KIND_MEASURE;
        end
    end

    // Position state moves on as soon as a beat is taken; the root comes later.
    always_comb
    begin
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        have_last_next = have_last_reg;
        seen_any_next  = seen_any_reg;
        if (accept) begin
            if (mode) begin
                have_last_next = 1'b0;
            end else begin
                last_x_next    = x_c;
                last_y_next    = y_c;
                have_last_next = 1'b1;
                seen_any_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            have_last_reg <= 1'b0;
            seen_any_reg  <= 1'b0;
        end else begin
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            have_last_reg <= have_last_next;
            seen_any_reg  <= seen_any_next;
        end
    end

endmodule

FILE: rtl/plo_queue.sv
// Two-entry queue between the front and back ends of the odometer.
// Depends on plo_pkg.
`timescale 1ns / 1ps

module plo_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  plo_pkg::entry_t push_entry,
    input  logic            push_valid,
    output logic            push_ready,
    output plo_pkg::entry_t pop_entry,
    output logic            pop_valid,
    input  logic            pop
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    plo_pkg::entry_t slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/plo_back.sv
// Back end of the odometer: squares, takes the root bit by bit, applies the
// limit, keeps the saturating total and holds the result register.
// Depends on plo_pkg.
`timescale 1ns / 1ps

module plo_back #(
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  plo_pkg::entry_t                   pop_entry,
    input  logic                              pop_valid,
    output logic                              pop,
    input  logic [plo_pkg::LIMIT_W-1:0]       jump_limit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [plo_pkg::TOTAL_OUT_W-1:0]   total_distance,
    output logic [plo_pkg::LIMIT_W-1:0]       step_distance,
    output logic                              step_rejected,
    output logic                              data_seen
);

    plo_pkg::back_state_t state_reg, state_next;

    plo_pkg::kind_t                  kind_reg, kind_next;
    logic [plo_pkg::LIMIT_W-1:0]     ax_reg, ax_next;
    logic [plo_pkg::LIMIT_W-1:0]     ay_reg, ay_next;
    logic                            seen_reg, seen_next;
    logic [plo_pkg::SQ_W-1:0]        sq_reg, sq_next;
    logic [plo_pkg::ROOT_W-1:0]      root_reg, root_next;
    logic [plo_pkg::ROOT_W-1:0]      bit_reg, bit_next;
    logic [TOTAL_WIDTH-1:0]          sum_reg, sum_next;

    logic                            out_valid_reg, out_valid_next;
    logic [plo_pkg::TOTAL_OUT_W-1:0] total_reg, total_next;
    logic [plo_pkg::LIMIT_W-1:0]     step_reg, step_next;
    logic                            rej_reg, rej_next;
    logic                            seen_out_reg, seen_out_next;

    logic                            out_free;
    logic                            finish;
    logic [plo_pkg::LIMIT_W-1:0]     mul_a;
    logic [31:0]                     mul_p;
    logic [plo_pkg::ROOT_W-1:0]      trial;
    logic [2*plo_pkg::ROOT_W-1:0]    trial_sq;
    logic                            root_over;
    logic [TOTAL_WIDTH:0]            sum_add;
    logic [TOTAL_WIDTH-1:0]          sum_sat;
    logic [63:0]                     sum_wide;

    assign out_free = !out_valid_reg || out_ready;

    // One 16x16 multiplier squares ax, then ay.
    assign mul_a = (state_reg == plo_pkg::BK_SQX) ? ax_reg : ay_reg;
    assign mul_p = 32'(mul_a) * 32'(mul_a);

    assign trial     = root_reg | bit_reg;
    assign trial_sq  = (2*plo_pkg::ROOT_W)'(trial) * (2*plo_pkg::ROOT_W)'(trial);
    assign root_over = (root_reg >= plo_pkg::ROOT_W'(jump_limit));

    assign sum_add = {1'b0, sum_reg} + (TOTAL_WIDTH+1)'(root_reg[plo_pkg::LIMIT_W-1:0]);
    assign sum_sat = sum_add[TOTAL_WIDTH] ? '1 : sum_add[TOTAL_WIDTH-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plo_pkg::BK_IDLE:
            begin
                if (pop_valid) begin
                    state_next = (pop_entry.kind == plo_pkg::KIND_MEASURE) ?
                                 plo_pkg::BK_SQX : plo_pkg::BK_DONE;
                end
            end
            plo_pkg::BK_SQX:  state_next = plo_pkg::BK_SQY;
            plo_pkg::BK_SQY:  state_next = plo_pkg::BK_ROOT;
            plo_pkg::BK_ROOT:
            begin
                if (bit_reg[0]) begin
                    state_next = plo_pkg::BK_DONE;
                end
            end
            plo_pkg::BK_DONE:
            begin
                if (out_free) begin
                    state_next = plo_pkg::BK_IDLE;
                end
            end
            default: state_next = plo_pkg::BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop    = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            plo_pkg::BK_IDLE: pop    = pop_valid;
            plo_pkg::BK_DONE: finish = out_free;
            default:
            begin
                pop    = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        kind_next      = kind_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        seen_next      = seen_reg;
        sq_next        = sq_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        total_next     = total_reg;
        step_next      = step_reg;
        rej_next       = rej_reg;
        seen_out_next  = seen_out_reg;

        if (pop) begin
            kind_next = pop_entry.kind;
            ax_next   = pop_entry.ax;
            ay_next   = pop_entry.ay;
            seen_next = pop_entry.seen;
            root_next = '0;
            bit_next  = {1'b1, {(plo_pkg::ROOT_W-1){1'b0}}};
        end

        if (state_reg == plo_pkg::BK_SQX) begin
            sq_next = plo_pkg::SQ_W'(mul_p);
        end
        if (state_reg == plo_pkg::BK_SQY) begin
            sq_next = sq_reg + plo_pkg::SQ_W'(mul_p);
        end
        if (state_reg == plo_pkg::BK_ROOT) begin
            if (trial_sq <= (2*plo_pkg::ROOT_W)'(sq_reg)) begin
                root_next = trial;
            end
            bit_next = bit_reg >> 1;
        end

        if (finish) begin
            step_next = '0;
            rej_next  = 1'b0;
            case (kind_reg)
                plo_pkg::KIND_CLEAR:  sum_next = '0;
                plo_pkg::KIND_REJECT: rej_next = 1'b1;
                plo_pkg::KIND_MEASURE:
                begin
                    if (root_over) begin
                        rej_next = 1'b1;
                    end else begin
                        step_next = root_reg[plo_pkg::LIMIT_W-1:0];
                        sum_next  = sum_sat;
                    end
                end
                default: sum_next = sum_reg;
            endcase
            out_valid_next = 1'b1;
            seen_out_next  = seen_reg;
            total_next     = sum_wide[plo_pkg::TOTAL_OUT_W-1:0];
        end
    end

    assign sum_wide = 64'(sum_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= plo_pkg::BK_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        seen_reg     <= seen_next;
        sq_reg       <= sq_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        total_reg    <= total_next;
        step_reg     <= step_next;
        rej_reg      <= rej_next;
        seen_out_reg <= seen_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign total_distance = total_reg;
    assign step_distance  = step_reg;
    assign step_rejected  = rej_reg;
    assign data_seen      = seen_out_reg;

    a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plo_pkg::BK_ROOT) |-> $onehot(bit_reg))
        else $error("root iteration lost its bit position");

    a_root_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plo_pkg::BK_ROOT) |=>
        (state_reg == plo_pkg::BK_ROOT || state_reg == plo_pkg::BK_DONE))
        else $error("root iteration left early");

    a_reject_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rej_reg) |-> (step_reg == '0))
        else $error("rejected step carries a distance");

    a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && step_reg != '0) |-> (step_reg < jump_limit))
        else $error("accepted step at or above the jump limit");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == plo_pkg::BK_IDLE && pop_valid))
        else $error("queue popped outside idle");

endmodule

FILE: test/odometer_checker.sv
// Scoreboard for the path length odometer: watches the input, output and
// jump limit ports, predicts each reading and compares it field by field.
// Depends on plo_pkg.
`timescale 1ns / 1ps

module odometer_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               mode,
    input  logic signed [plo_pkg::POS_W-1:0]   pos_x,
    input  logic signed [plo_pkg::POS_W-1:0]   pos_y,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [plo_pkg::TOTAL_OUT_W-1:0]    total_distance,
    input  logic [plo_pkg::LIMIT_W-1:0]        step_distance,
    input  logic                               step_rejected,
    input  logic                               data_seen,
    input  logic                               cfg_we,
    input  logic [plo_pkg::LIMIT_W-1:0]        cfg_wdata,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 readings_checked,
    output int                                 steps_dropped
);

    localparam logic [plo_pkg::TOTAL_OUT_W-1:0] SUM_CEILING = '1;

    typedef struct packed {
        logic [plo_pkg::TOTAL_OUT_W-1:0] total;
        logic [plo_pkg::LIMIT_W-1:0]     step_len;
        logic                            dropped;
        logic                            seen;
    } reading_t;

    // Model of the odometer state, updated at each accepted input beat and config write.
    logic signed [plo_pkg::POS_W-1:0]  prev_x;
    logic signed [plo_pkg::POS_W-1:0]  prev_y;
    logic                              prev_valid;
    logic                              any_sample;
    logic [plo_pkg::TOTAL_OUT_W-1:0]   path_sum;
    logic [plo_pkg::LIMIT_W-1:0]       jump_limit_q;

    reading_t readings_due[$];
    reading_t want;
    int       errs;
    int       checked;
    int       dropped_cnt;

    function automatic logic [plo_pkg::ROOT_W-1:0] floor_root(
        input logic [plo_pkg::SQ_W:0] v);
        logic [plo_pkg::ROOT_W-1:0] root;
        logic [plo_pkg::ROOT_W-1:0] trial;
        root = '0;
        for (int k = plo_pkg::ROOT_W - 1; k >= 0; k--) begin
            trial = root | (plo_pkg::ROOT_W'(1) << k);
            if (40'(trial) * 40'(trial) <= 40'(v))
                root = trial;
        end
        return root;
    endfunction

    function automatic reading_t advance_odometer(
        input logic                             clr,
        input logic signed [plo_pkg::POS_W-1:0] x,
        input logic signed [plo_pkg::POS_W-1:0] y);
        reading_t                        r;
        logic signed [plo_pkg::POS_W:0]  dx;
        logic signed [plo_pkg::POS_W:0]  dy;
        logic [plo_pkg::POS_W:0]         ax;
        logic [plo_pkg::POS_W:0]         ay;
        logic [plo_pkg::SQ_W:0]          sq;
        logic [plo_pkg::ROOT_W-1:0]      root;
        r = '0;
        if (clr) begin
            path_sum   = '0;
            prev_valid = 1'b0;
        end
        else begin
            if (prev_valid) begin
                // Deltas are taken one bit wider so that a jump across the
                // coordinate wrap point stays a huge step.
                dx = {x[plo_pkg::POS_W-1], x} - {prev_x[plo_pkg::POS_W-1], prev_x};
                dy = {y[plo_pkg::POS_W-1], y} - {prev_y[plo_pkg::POS_W-1], prev_y};
                ax = dx[plo_pkg::POS_W] ? -dx : dx;
                ay = dy[plo_pkg::POS_W] ? -dy : dy;
                if (ax >= jump_limit_q || ay >= jump_limit_q) begin
                    r.dropped = 1'b1;
                end
                else begin
                    sq = (plo_pkg::SQ_W + 1)'(ax[plo_pkg::LIMIT_W-1:0])
                           * (plo_pkg::SQ_W + 1)'(ax[plo_pkg::LIMIT_W-1:0])
                       + (plo_pkg::SQ_W + 1)'(ay[plo_pkg::LIMIT_W-1:0])
                           * (plo_pkg::SQ_W + 1)'(ay[plo_pkg::LIMIT_W-1:0]);
                    root = floor_root(sq);
                    if (root >= jump_limit_q) begin
                        r.dropped = 1'b1;
                    end
                    else begin
                        r.step_len = root[plo_pkg::LIMIT_W-1:0];
                        if (SUM_CEILING - path_sum < plo_pkg::TOTAL_OUT_W'(root))
                            path_sum = SUM_CEILING;
                        else
                            path_sum = path_sum + plo_pkg::TOTAL_OUT_W'(root);
                    end
                end
            end
            prev_x     = x;
            prev_y     = y;
            prev_valid = 1'b1;
            any_sample = 1'b1;
        end
        r.total = path_sum;
        r.seen  = any_sample;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, want_v, got_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_x           = '0;
            prev_y           = '0;
            prev_valid       = 1'b0;
            any_sample       = 1'b0;
            path_sum         = '0;
            jump_limit_q     = plo_pkg::LIMIT_RESET;
            errs             = 0;
            checked          = 0;
            dropped_cnt      = 0;
            readings_due.delete();
            fail_count       <= 0;
            pending          <= 0;
            readings_checked <= 0;
            steps_dropped    <= 0;
        end
        else begin
            if (cfg_we)
                jump_limit_q = cfg_wdata;
            if (in_valid && in_ready)
                readings_due.push_back(advance_odometer(mode, pos_x, pos_y));
            if (out_valid && out_ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, total %0d step %0d",
                             $time, total_distance, step_distance);
                    errs++;
                end
                else begin
                    want = readings_due.pop_front();
                    check_field("total_distance", 64'(want.total), 64'(total_distance));
                    check_field("step_distance", 64'(want.step_len), 64'(step_distance));
                    check_field("step_rejected", 64'(want.dropped), 64'(step_rejected));
                    check_field("data_seen", 64'(want.seen), 64'(data_seen));
                    checked++;
                    if (want.dropped)
                        dropped_cnt++;
                end
            end
            fail_count       <= errs;
            pending          <= readings_due.size();
            readings_checked <= checked;
            steps_dropped    <= dropped_cnt;
        end
    end

endmodule

FILE: test/tb.sv
// Top of the path length odometer testbench: clock, reset, stimulus, result
// sink with random stalls, and the final verdict. Depends on plo_pkg,
// path_length_odometer and odometer_checker.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 3000;  // cycles with no beat on either side
    localparam int SETTLE     = 40;    // longest back end latency plus margin
    localparam int HOLD_AT    = 420;   // result count at which the sink holds off
    localparam int HOLD_OFF   = 250;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic                              mode;
    logic signed [plo_pkg::POS_W-1:0]  pos_x;
    logic signed [plo_pkg::POS_W-1:0]  pos_y;
    logic                              out_valid;
    logic                              out_ready;
    logic [plo_pkg::TOTAL_OUT_W-1:0]   total_distance;
    logic [plo_pkg::LIMIT_W-1:0]       step_distance;
    logic                              step_rejected;
    logic                              data_seen;
    logic                              cfg_we;
    logic [plo_pkg::LIMIT_W-1:0]       cfg_wdata;

    int fail_count;
    int pending;
    int readings_checked;
    int steps_dropped;

    logic signed [plo_pkg::POS_W-1:0] cur_x;
    logic signed [plo_pkg::POS_W-1:0] cur_y;
    bit                               no_gaps;
    int                               beats_sent;
    int                               clears_sent;
    int                               limits_used;
    int                               results_taken;
    int                               quiet;

    logic [plo_pkg::POS_W-1:0] corners [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    logic [plo_pkg::LIMIT_W-1:0] phase_limits [10];

    path_length_odometer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_distance (total_distance),
        .step_distance  (step_distance),
        .step_rejected  (step_rejected),
        .data_seen      (data_seen),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    odometer_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .total_distance   (total_distance),
        .step_distance    (step_distance),
        .step_rejected    (step_rejected),
        .data_seen        (data_seen),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .pending          (pending),
        .readings_checked (readings_checked),
        .steps_dropped    (steps_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic offer(input logic m, input logic [plo_pkg::POS_W-1:0] x,
                         input logic [plo_pkg::POS_W-1:0] y);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        pos_x    <= x;
        pos_y    <= y;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        if (m)
            clears_sent++;
    endtask

    task automatic sample_at(input logic [plo_pkg::POS_W-1:0] x,
                             input logic [plo_pkg::POS_W-1:0] y);
        cur_x = x;
        cur_y = y;
        offer(1'b0, x, y);
    endtask

    task automatic step_by(input longint dx, input longint dy);
        sample_at(plo_pkg::POS_W'(cur_x + dx), plo_pkg::POS_W'(cur_y + dy));
    endtask

    task automatic clear_total();
        offer(1'b1, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // The jump limit only changes while the block has nothing in flight.
    task automatic set_limit(input logic [plo_pkg::LIMIT_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limits_used++;
    endtask

    task automatic random_sample(input logic [plo_pkg::LIMIT_W-1:0] lim);
        int     pick;
        longint span;
        longint edge_len;
        longint diag;
        pick = $urandom_range(0, 99);
        span = (lim > 1) ? longint'(lim) - 1 : 3;
        if (pick < 55)
        begin
            // Ordinary walk: both deltas within the limit when the limit is above 1.
            step_by(longint'($urandom_range(0, 2 * span)) - span,
                    longint'($urandom_range(0, 2 * span)) - span);
        end
        else if (pick < 72)
        begin
            // One axis right around the limit.
            edge_len = longint'(lim) + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
                edge_len = -edge_len;
            diag = longint'($urandom_range(0, span / 4));
            if ($urandom_range(0, 1))
                step_by(edge_len, diag);
            else
                step_by(-diag, edge_len);
        end
        else if (pick < 85)
        begin
            // Diagonal step whose root lands around the limit.
            diag = longint'(real'(lim) * 0.70710678) + longint'($urandom_range(0, 2)) - 1;
            step_by($urandom_range(0, 1) ? diag : -diag,
                    $urandom_range(0, 1) ? diag : -diag);
        end
        else if (pick < 90)
        begin
            clear_total();
        end
        else if (pick < 96)
        begin
            sample_at($urandom, $urandom);
        end
        else
        begin
            sample_at(corners[$urandom_range(0, 3)], corners[$urandom_range(0, 3)]);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= 1'b0;
        pos_x       <= '0;
        pos_y       <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        cur_x       = '0;
        cur_y       = '0;
        no_gaps     = 1'b0;
        beats_sent  = 0;
        clears_sent = 0;
        limits_used = 0;
        phase_limits = '{16'd2048, 16'd65535, 16'd100, 16'd1, 16'd30000,
                         16'd0, 16'd7, 16'd1000, 16'd2, 16'd2048};
        phase_limits[7] = plo_pkg::LIMIT_W'($urandom_range(2, 65535));
        phase_limits[8] = plo_pkg::LIMIT_W'($urandom_range(2, 65535));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit of 2048.
        clear_total();                          // clear before any sample
        sample_at(32'sd0, 32'sd0);              // first sample, no step
        sample_at(32'sd3, 32'sd4);              // 3-4-5 step
        sample_at(32'sd3, 32'sd4);              // zero-length step
        sample_at(32'sd2050, 32'sd4);           // just under the limit
        sample_at(32'sd4098, 32'sd4);           // single delta at the limit
        sample_at(32'sd5598, 32'sd1504);        // root over the limit
        sample_at(32'h7FFF_FFFF, 32'sd0);       // huge jump
        sample_at(32'h8000_0000, 32'sd0);       // wraps to 1 in 32 bits, still huge
        sample_at(32'h8000_0003, -32'sd4);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        step_by(1447, -1447);                   // root just below the limit
        sample_at(-32'sd1, -32'sd1);
        clear_total();                          // clear keeps data_seen
        sample_at(32'sd100, 32'sd100);          // first sample after a clear
        step_by(1448, 1448);                    // root 2047.8, floored

        set_limit(16'd65535);
        sample_at(32'sd0, 32'sd0);
        step_by(65534, 0);                      // largest accepted single axis
        step_by(46341, 46341);                  // root 65536, rejected
        step_by(65535, 0);
        step_by(65534, 65534);                  // largest square
        step_by(46340, 46340);                  // root 65534, accepted

        set_limit(16'd1);
        step_by(0, 0);
        step_by(1, 0);
        set_limit(16'd0);
        step_by(0, 0);                          // a zero limit drops even a null step
        clear_total();

        // Random part, one phase per jump limit setting.
        foreach (phase_limits[p])
        begin
            set_limit(phase_limits[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ((phase_limits[p] <= 1) ? 60 : 175)
                random_sample(phase_limits[p]);
        end
        no_gaps = 1'b0;

        wait_drained();
        $display("Drove %0d input beats (%0d clears) over %0d jump limit settings.",
                 beats_sent, clears_sent, limits_used);
        $display("Checked %0d readings, %0d of them dropped steps.",
                 readings_checked, steps_dropped);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result sink: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        int stall;
        out_ready     <= 1'b0;
        results_taken = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (results_taken == HOLD_AT)
                stall = HOLD_OFF;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

endmodule
